### rtl/fkhc_pkg.sv
// Shared types, codes and the hash step of the form key hash collision detector.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package fkhc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned HashW  = 32;
  localparam int unsigned CountW = 24;
  localparam int unsigned LimitW = 16;
  localparam int unsigned CfgW   = 24;

  localparam logic [HashW-1:0]  HashSeed  = 32'd5381;
  localparam int unsigned       HashShift = 5;
  localparam logic [ByteW-1:0]  KeyEnd    = 8'h3D;  // '='
  localparam logic [ByteW-1:0]  PairEnd   = 8'h26;  // '&'
  localparam logic [CountW-1:0] CountMax  = 24'hFFFFFF;

  localparam logic [LimitW-1:0] ScanLimitRst = 16'd1024;
  localparam logic [CountW-1:0] MinBodyRst   = 24'd1024;

  // register indexes of the configuration port
  localparam logic CfgScanLimit = 1'b0;
  localparam logic CfgMinBody   = 1'b1;

  // verdict codes
  localparam logic [1:0] VerdictShort  = 2'd0;
  localparam logic [1:0] VerdictClean  = 2'd1;
  localparam logic [1:0] VerdictAttack = 2'd2;

  typedef struct packed {
    logic [1:0]       verdict;
    logic [HashW-1:0] first_key_hash;
  } result_t;

  // ASCII upper-casing of 'a'..'z' only
  function automatic logic [ByteW-1:0] upper_ascii(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    r = b;
    if (b >= 8'h61 && b <= 8'h7A) begin
      r = b - 8'h20;
    end
    return r;
  endfunction

  // h * 33 xor upper(b), modulo 2^32
  function automatic logic [HashW-1:0] hash_step(input logic [HashW-1:0] h,
                                                 input logic [ByteW-1:0] b);
    return ((h << HashShift) + h) ^ {{(HashW-ByteW){1'b0}}, upper_ascii(b)};
  endfunction

endpackage

### rtl/fkhc_in_if.sv
// Input channel of the form key hash collision detector: one body byte per item.
// Uses fkhc_pkg for the byte width.
interface fkhc_in_if;
  logic                      valid;
  logic                      ready;
  logic [fkhc_pkg::ByteW-1:0] body_byte;
  logic                      end_of_body;

  modport source (output valid, body_byte, end_of_body, input ready);
  modport sink   (input valid, body_byte, end_of_body, output ready);
endinterface

### rtl/fkhc_out_if.sv
// Output channel of the form key hash collision detector: one verdict per body.
// Uses fkhc_pkg for the hash width.
interface fkhc_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 verdict;
  logic [fkhc_pkg::HashW-1:0] first_key_hash;

  modport source (output valid, verdict, first_key_hash, input ready);
  modport sink   (input valid, verdict, first_key_hash, output ready);
endinterface

### rtl/fkhc_cfg.sv
// Configuration registers (scan limit, minimum body length) behind a plain write port.
// Uses fkhc_pkg for widths, register indexes and reset values.
module fkhc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [fkhc_pkg::CfgW-1:0]     cfg_wdata_i,
  output logic [fkhc_pkg::LimitW-1:0]   scan_limit_o,
  output logic [fkhc_pkg::CountW-1:0]   min_body_o
);

  logic [fkhc_pkg::LimitW-1:0] scan_limit_q, scan_limit_d;
  logic [fkhc_pkg::CountW-1:0] min_body_q, min_body_d;

  // decode the write
  always_comb begin
    scan_limit_d = scan_limit_q;
    min_body_d   = min_body_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        fkhc_pkg::CfgScanLimit: scan_limit_d = cfg_wdata_i[fkhc_pkg::LimitW-1:0];
        fkhc_pkg::CfgMinBody:   min_body_d   = cfg_wdata_i[fkhc_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_limit_q <= fkhc_pkg::ScanLimitRst;
      min_body_q   <= fkhc_pkg::MinBodyRst;
    end else begin
      scan_limit_q <= scan_limit_d;
      min_body_q   <= min_body_d;
    end
  end

  assign scan_limit_o = scan_limit_q;
  assign min_body_o   = min_body_q;

endmodule

### rtl/fkhc_scan.sv
// Per-body scan state: key phase, running and saved hash, byte count, attack flag.
// Uses fkhc_pkg for the hash step, constants and the result struct.
module fkhc_scan (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [fkhc_pkg::ByteW-1:0]   byte_i,
  input  logic                         last_i,
  input  logic [fkhc_pkg::LimitW-1:0]  scan_limit_i,
  input  logic [fkhc_pkg::CountW-1:0]  min_body_i,
  output fkhc_pkg::result_t            result_o
);

  localparam logic [1:0] PhKey1 = 2'd0;
  localparam logic [1:0] PhSkip = 2'd1;
  localparam logic [1:0] PhKey2 = 2'd2;
  localparam logic [1:0] PhDone = 2'd3;

  logic [1:0]                  phase_q, phase_d;
  logic [fkhc_pkg::HashW-1:0]  run_hash_q, run_hash_d;
  logic [fkhc_pkg::HashW-1:0]  saved_hash_q, saved_hash_d;
  logic [fkhc_pkg::CountW-1:0] count_q, count_d;
  logic                        attack_q, attack_d;
  logic                        in_scan;
  logic [fkhc_pkg::HashW-1:0]  stepped_hash;

  assign in_scan      = count_q < {{(fkhc_pkg::CountW-fkhc_pkg::LimitW){1'b0}}, scan_limit_i};
  assign stepped_hash = fkhc_pkg::hash_step(run_hash_q, byte_i);

  // advance the key state machine by one byte
  always_comb begin
    phase_d      = phase_q;
    run_hash_d   = run_hash_q;
    saved_hash_d = saved_hash_q;
    attack_d     = attack_q;
    if (in_scan) begin
      unique case (phase_q)
        PhKey1: begin
          if (byte_i == fkhc_pkg::KeyEnd) begin
            saved_hash_d = run_hash_q;
            phase_d      = PhSkip;
          end else begin
            run_hash_d = stepped_hash;
          end
        end
        PhSkip: begin
          if (byte_i == fkhc_pkg::PairEnd) begin
            run_hash_d = fkhc_pkg::HashSeed;
            phase_d    = PhKey2;
          end
        end
        PhKey2: begin
          if (byte_i == fkhc_pkg::KeyEnd) begin
            attack_d = (run_hash_q == saved_hash_q);
            phase_d  = PhDone;
          end else begin
            run_hash_d = stepped_hash;
          end
        end
        default: ;
      endcase
    end
    count_d = (count_q < fkhc_pkg::CountMax) ? count_q + 1'b1 : count_q;
  end

  // verdict from the state after this byte
  always_comb begin
    if (count_d < min_body_i) begin
      result_o.verdict = fkhc_pkg::VerdictShort;
    end else if (attack_d) begin
      result_o.verdict = fkhc_pkg::VerdictAttack;
    end else begin
      result_o.verdict = fkhc_pkg::VerdictClean;
    end
    result_o.first_key_hash = (phase_d == PhKey1) ? '0 : saved_hash_d;
  end

  // hold between bytes, clear after the final byte of a body
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhKey1;
      run_hash_q   <= fkhc_pkg::HashSeed;
      saved_hash_q <= '0;
      count_q      <= '0;
      attack_q     <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q      <= PhKey1;
        run_hash_q   <= fkhc_pkg::HashSeed;
        saved_hash_q <= '0;
        count_q      <= '0;
        attack_q     <= 1'b0;
      end else begin
        phase_q      <= phase_d;
        run_hash_q   <= run_hash_d;
        saved_hash_q <= saved_hash_d;
        count_q      <= count_d;
        attack_q     <= attack_d;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> phase_q == PhKey1 && count_q == '0 && !attack_q)
    else $error("scan state not cleared after final byte");

  a_attack_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    attack_q |-> phase_q == PhDone)
    else $error("attack flag set before second key ended");

  a_saved_zero_key1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhKey1 |-> saved_hash_q == '0)
    else $error("saved hash nonzero during first key");

endmodule

### rtl/form_key_hash_collision_detector.sv
// Top level of the form key hash collision detector: input register, scan, result register.
// Uses fkhc_pkg, fkhc_in_if, fkhc_out_if, fkhc_cfg and fkhc_scan.
//
// The block takes one body byte per clock while no final byte waits on a pending result: the
// case-folded hash update (h*33 xor byte), the '=' / '&' compares and the saturating byte
// count form a combinational path from the input register into the scan state registers. The
// verdict is loaded into the result register when the final byte of a body steps out of the
// input register, and is held there until taken; while it waits, non-final bytes of the next
// body keep flowing, and only another final byte waits for the result to be taken. There is
// no clearing pass after reset. Write the scan limit (index 0) and the minimum body length
// (index 1) only between bodies.
module form_key_hash_collision_detector (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  fkhc_in_if.sink                    in_i,
  fkhc_out_if.source                 out_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [fkhc_pkg::CfgW-1:0]  cfg_wdata_i
);

  logic [fkhc_pkg::LimitW-1:0] scan_limit;
  logic [fkhc_pkg::CountW-1:0] min_body;

  logic                       s1_valid_q;
  logic [fkhc_pkg::ByteW-1:0] s1_byte_q;
  logic                       s1_last_q;
  logic                       s1_step;
  logic                       in_take;

  logic                       out_valid_q;
  fkhc_pkg::result_t          out_res_q;
  fkhc_pkg::result_t          scan_res;

  fkhc_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .scan_limit_o (scan_limit),
    .min_body_o   (min_body)
  );

  // a final byte needs a free result register; other bytes always proceed
  assign s1_step = s1_valid_q && (!s1_last_q || !out_valid_q || out_o.ready);
  assign in_take = in_i.valid && in_i.ready;
  assign in_i.ready = !s1_valid_q || s1_step;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= in_i.body_byte;
      s1_last_q <= in_i.end_of_body;
    end
  end

  fkhc_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (s1_step),
    .byte_i       (s1_byte_q),
    .last_i       (s1_last_q),
    .scan_limit_i (scan_limit),
    .min_body_i   (min_body),
    .result_o     (scan_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && !out_o.ready) || (s1_step && s1_last_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_step && s1_last_q) begin
      out_res_q <= scan_res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.verdict        = out_res_q.verdict;
  assign out_o.first_key_hash = out_res_q.first_key_hash;

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_res_q.verdict != 2'd3)
    else $error("undefined verdict code on output");

  a_final_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_step && s1_last_q |=> out_valid_q)
    else $error("final byte did not load a result");

  a_final_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_last_q && out_valid_q && !out_o.ready |-> !s1_step && !in_i.ready)
    else $error("final byte advanced over a pending result");

endmodule
